[design/tfc_pkg.sv]
// Shared constants, types and CRC function for the telemetry frame checker.
package tfc_pkg;

    localparam int FRAME_BYTES = 22;
    localparam int CNT_W       = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] POS_SYNC0    = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SYNC1    = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_VERSION  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CRC_LOW  = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] POS_CRC_HIGH = CNT_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  SYNC_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [7:0]  VERSION_RST = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Bytewise reflected CRC-16 update, eight shift steps unrolled
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/tfc_in_stage.sv]
// Input register stage of the telemetry frame checker.
module tfc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tfc_pkg::t_in_word i_word,
    output logic              o_valid,
    output tfc_pkg::t_in_word o_word,
    input  logic              i_take
);

    logic              r_valid;
    logic              n_valid;
    tfc_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

[design/tfc_check.sv]
// Frame state, header and CRC check, and result register.
module tfc_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_version,
    input  logic              i_valid,
    input  tfc_pkg::t_in_word i_word,
    output logic              o_take,
    output logic              o_res_valid,
    output logic              o_res_ok,
    input  logic              i_res_ready
);

    logic [tfc_pkg::CNT_W-1:0] r_count;
    logic [tfc_pkg::CNT_W-1:0] n_count;
    logic [15:0]               r_crc;
    logic [15:0]               n_crc;
    logic                      r_hdr_err;
    logic                      n_hdr_err;
    logic [7:0]                r_crc_low;
    logic [7:0]                n_crc_low;
    logic                      r_crc_err;
    logic                      n_crc_err;
    logic                      r_res_valid;
    logic                      n_res_valid;
    logic                      r_res_ok;
    logic                      n_res_ok;
    logic                      out_free;
    logic                      step;
    logic                      frame_end;
    logic [7:0]                b;

    assign b         = i_word.data_byte;
    assign out_free  = !r_res_valid || i_res_ready;
    assign step      = i_valid && (!i_word.last_byte || out_free);
    assign frame_end = step && i_word.last_byte;
    assign o_take    = step;

    always_comb begin
        n_count   = r_count;
        n_crc     = r_crc;
        n_hdr_err = r_hdr_err;
        n_crc_low = r_crc_low;
        n_crc_err = r_crc_err;
        if (step) begin
            if (r_count == tfc_pkg::POS_SYNC0 && b != tfc_pkg::SYNC_FIRST) begin
                n_hdr_err = 1'b1;
            end
            if (r_count == tfc_pkg::POS_SYNC1 && b != tfc_pkg::SYNC_SECOND) begin
                n_hdr_err = 1'b1;
            end
            if (r_count == tfc_pkg::POS_VERSION && b != i_version) begin
                n_hdr_err = 1'b1;
            end
            if (r_count < tfc_pkg::POS_CRC_LOW) begin
                n_crc = tfc_pkg::crc_update(r_crc, b);
            end else if (r_count == tfc_pkg::POS_CRC_LOW) begin
                n_crc_low = b;
            end else if (r_count == tfc_pkg::POS_CRC_HIGH) begin
                if ({b, r_crc_low} != r_crc) begin
                    n_crc_err = 1'b1;
                end
            end
            if (r_count != tfc_pkg::COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        n_res_ok    = r_res_ok;
        if (frame_end) begin
            n_res_valid = 1'b1;
            n_res_ok    = (r_count == tfc_pkg::POS_CRC_HIGH) && !n_hdr_err && !n_crc_err;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_end) begin
            r_count   <= '0;
            r_crc     <= tfc_pkg::CRC_INIT;
            r_hdr_err <= 1'b0;
            r_crc_low <= '0;
            r_crc_err <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_hdr_err <= n_hdr_err;
            r_crc_low <= n_crc_low;
            r_crc_err <= n_crc_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_ok <= n_res_ok;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_ok    = r_res_ok;

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> (r_count == '0 && r_crc == tfc_pkg::CRC_INIT && !r_hdr_err && !r_crc_err))
        else $error("frame state not restarted after last word");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_word.last_byte && r_count != tfc_pkg::COUNT_MAX)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("byte count did not advance");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_count) && $stable(r_crc))
        else $error("frame state changed without a word");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(frame_end))
        else $error("result raised without a frame end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |-> !frame_end)
        else $error("pending result overwritten");

endmodule

[design/telemetry_frame_checker.sv]
// Top level of the telemetry frame checker.
//  channel   direction  word                      handshake
//  s_axis    in         tdata=data_byte, tlast     tvalid/tready
//  m_axis    out        tdata[0]=frame_ok          tvalid/tready
//  cfg       in         protocol_version           i_cfg_valid/o_cfg_ready
// One word per cycle while no pending result stalls a last byte; a word is held
// in the input register, then the CRC/header update writes the result register.
// Result valid follows a last byte through the input and then the result register.
// Reset: synchronous active low; version returns to 1, frame state restarts.
// A pending result stalls only a last byte; other bytes keep flowing.
module telemetry_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] frame_ok, [7:1] zero
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]        r_version;
    tfc_pkg::t_in_word in_word;
    tfc_pkg::t_in_word st_word;
    logic              st_valid;
    logic              st_take;
    logic              res_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= tfc_pkg::VERSION_RST;
        end else if (i_cfg_valid) begin
            r_version <= i_cfg_data;
        end
    end

    assign in_word.data_byte = s_axis_tdata;
    assign in_word.last_byte = s_axis_tlast;

    tfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (st_valid),
        .o_word  (st_word),
        .i_take  (st_take)
    );

    tfc_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_version   (r_version),
        .i_valid     (st_valid),
        .i_word      (st_word),
        .o_take      (st_take),
        .o_res_valid (m_axis_tvalid),
        .o_res_ok    (res_ok),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, res_ok};

endmodule
